>>> sv/dtc_pkg.sv
// ----------------------------------------------------------------------------
// dtc_pkg
// Types, register indexes and constants shared by the disk drive and timer
// controller.
// ----------------------------------------------------------------------------
package dtc_pkg;

    localparam int unsigned DISK_BYTES   = 131072;
    localparam int unsigned OFFSET_SPAN  = 131072;
    localparam int unsigned DISK_LIMIT_I = (DISK_BYTES < OFFSET_SPAN) ? DISK_BYTES : OFFSET_SPAN;

    localparam int OFFSET_W = 17;
    localparam int LENGTH_W = 18;
    localparam int WAIT_W   = 20;
    localparam int TIMER_W  = 16;

    localparam logic [LENGTH_W-1:0] DISK_LIMIT     = LENGTH_W'(DISK_LIMIT_I);
    localparam logic [LENGTH_W-1:0] LENGTH_RESET   = 18'd65536;
    localparam logic [WAIT_W-1:0]   WAIT_INSERT    = 20'd895000;
    localparam logic [WAIT_W-1:0]   WAIT_SIDE_END  = 20'd5000;
    localparam logic [WAIT_W-1:0]   WAIT_BYTE      = 20'd150;
    localparam logic [7:0]          STATUS_FIXED   = 8'h80;
    localparam logic [7:0]          EXT_CONN_VALUE = 8'h80;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_READ   = 2'd1,
        KIND_WRITE  = 2'd2,
        KIND_INSERT = 2'd3
    } kind_t;

    localparam logic [4:0] REG_TIMER_LO     = 5'h00;
    localparam logic [4:0] REG_TIMER_HI     = 5'h01;
    localparam logic [4:0] REG_TIMER_CTRL   = 5'h02;
    localparam logic [4:0] REG_IO_ENABLE    = 5'h03;
    localparam logic [4:0] REG_WRITE_DATA   = 5'h04;
    localparam logic [4:0] REG_DRIVE_CTRL   = 5'h05;
    localparam logic [4:0] REG_DISK_STATUS  = 5'h10;
    localparam logic [4:0] REG_READ_DATA    = 5'h11;
    localparam logic [4:0] REG_DRIVE_STATUS = 5'h12;
    localparam logic [4:0] REG_EXT_CONN     = 5'h13;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] reg_index;
        logic [7:0] write_value;
        logic [7:0] disk_byte;
    } item_t;

    typedef struct packed {
        logic                nametable_horizontal;
        logic [7:0]          disk_write_data;
        logic                disk_write;
        logic [OFFSET_W-1:0] disk_address;
        logic                drive_irq;
        logic                timer_irq;
        logic [7:0]          read_value;
    } result_t;

    typedef struct packed {
        logic rep;
        logic en;
        logic irq;
    } timer_flags_t;

    typedef struct packed {
        logic irqen;
        logic ready;
        logic crc;
        logic rd;
        logic halt;
        logic power;
    } drive_ctrl_t;

    typedef struct packed {
        logic gap;
        logic scanning;
        logic empty;
        logic xfer;
        logic irq;
    } drive_status_t;

endpackage

>>> sv/dtc_core.sv
// ----------------------------------------------------------------------------
// dtc_core
// Controller state and the single-pass update for one request: timer
// countdown, drive wait and byte transfer, register reads and writes, disk insert.
// ----------------------------------------------------------------------------
module dtc_core import dtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  item_t               item,
    input  logic                cfg_wr_en,
    input  logic [LENGTH_W-1:0] cfg_wr_data,
    output result_t             result
);

    logic [LENGTH_W-1:0] disk_length_reg,  disk_length_next;
    logic [7:0]          data_byte_reg,    data_byte_next;
    logic                io_enable_reg,    io_enable_next;
    logic                mirror_reg,       mirror_next;
    logic [TIMER_W-1:0]  timer_reload_reg, timer_reload_next;
    logic [TIMER_W-1:0]  timer_count_reg,  timer_count_next;
    timer_flags_t        timer_flags_reg,  timer_flags_next;
    drive_ctrl_t         drive_ctrl_reg,   drive_ctrl_next;
    drive_status_t       drive_status_reg, drive_status_next;
    logic [OFFSET_W-1:0] offset_reg,       offset_next;
    logic [WAIT_W-1:0]   wait_reg,         wait_next;

    logic [TIMER_W-1:0]  timer_dec;
    logic [WAIT_W-1:0]   wait_dec;
    logic [LENGTH_W-1:0] offset_inc;

    assign timer_dec  = timer_count_reg - 1'b1;
    assign wait_dec   = wait_reg - 1'b1;
    assign offset_inc = {1'b0, offset_reg} + 1'b1;

    always_comb begin
        data_byte_next    = data_byte_reg;
        io_enable_next    = io_enable_reg;
        mirror_next       = mirror_reg;
        timer_reload_next = timer_reload_reg;
        timer_count_next  = timer_count_reg;
        timer_flags_next  = timer_flags_reg;
        drive_ctrl_next   = drive_ctrl_reg;
        drive_status_next = drive_status_reg;
        offset_next       = offset_reg;
        wait_next         = wait_reg;
        result            = '0;

        unique case (item.kind)
            KIND_TICK: begin
                if (timer_flags_reg.en) begin
                    timer_count_next = timer_dec;
                    if (timer_dec == '0) begin
                        timer_flags_next.irq = 1'b1;
                        timer_count_next     = timer_reload_reg;
                        if (!timer_flags_reg.rep) begin
                            timer_flags_next.en = 1'b0;
                        end
                    end
                end
                if (!drive_ctrl_reg.power) begin
                    offset_next                = '0;
                    drive_status_next.scanning = 1'b0;
                    drive_status_next.gap      = 1'b1;
                    wait_next                  = WAIT_SIDE_END;
                end else if (!(drive_ctrl_reg.halt && !drive_status_reg.empty
                               && !drive_status_reg.scanning)) begin
                    wait_next = wait_dec;
                    if (wait_dec == '0) begin
                        drive_status_next.empty    = 1'b0;
                        drive_status_next.scanning = 1'b1;
                        result.disk_address        = offset_reg;
                        if (drive_ctrl_reg.rd) begin
                            if (!drive_ctrl_reg.ready) begin
                                drive_status_next.gap = 1'b1;
                            end else if (drive_status_reg.gap) begin
                                if (item.disk_byte != 8'd0) begin
                                    drive_status_next.gap = 1'b0;
                                end
                            end else begin
                                data_byte_next         = item.disk_byte;
                                drive_status_next.xfer = 1'b1;
                                if (drive_ctrl_reg.irqen) begin
                                    drive_status_next.irq = 1'b1;
                                end
                            end
                        end else begin
                            result.disk_write = 1'b1;
                            if (drive_ctrl_reg.ready && !drive_ctrl_reg.crc) begin
                                result.disk_write_data = data_byte_reg;
                                drive_status_next.xfer = 1'b1;
                                if (drive_ctrl_reg.irqen) begin
                                    drive_status_next.irq = 1'b1;
                                end
                            end
                        end
                        if (offset_inc >= disk_length_reg || offset_inc >= DISK_LIMIT) begin
                            offset_next                = '0;
                            drive_status_next.scanning = 1'b0;
                            drive_status_next.gap      = 1'b1;
                            wait_next                  = WAIT_SIDE_END;
                        end else begin
                            offset_next = offset_inc[OFFSET_W-1:0];
                            wait_next   = WAIT_BYTE;
                        end
                    end
                end
            end
            KIND_READ: begin
                unique case (item.reg_index)
                    REG_DISK_STATUS: begin
                        if (io_enable_reg) begin
                            result.read_value = STATUS_FIXED
                                | {6'd0, drive_status_reg.xfer, timer_flags_reg.irq};
                            drive_status_next.xfer = 1'b0;
                        end
                        drive_status_next.irq = 1'b0;
                        timer_flags_next.irq  = 1'b0;
                    end
                    REG_READ_DATA: begin
                        if (io_enable_reg) begin
                            result.read_value      = data_byte_reg;
                            drive_status_next.xfer = 1'b0;
                        end
                        drive_status_next.irq = 1'b0;
                    end
                    REG_DRIVE_STATUS: begin
                        result.read_value = {5'd0, drive_status_reg.empty,
                                             !drive_status_reg.scanning,
                                             drive_status_reg.empty};
                    end
                    REG_EXT_CONN: begin
                        result.read_value = EXT_CONN_VALUE;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_WRITE: begin
                unique case (item.reg_index)
                    REG_TIMER_LO: begin
                        timer_reload_next[7:0] = item.write_value;
                    end
                    REG_TIMER_HI: begin
                        timer_reload_next[15:8] = item.write_value;
                    end
                    REG_TIMER_CTRL: begin
                        if (io_enable_reg) begin
                            timer_flags_next.rep = item.write_value[0];
                            timer_flags_next.en  = item.write_value[1];
                            if (item.write_value[1]) begin
                                timer_count_next = timer_reload_reg;
                            end else begin
                                timer_flags_next.irq = 1'b0;
                            end
                        end
                    end
                    REG_IO_ENABLE: begin
                        io_enable_next = item.write_value[0];
                        if (!item.write_value[0]) begin
                            timer_flags_next.en  = 1'b0;
                            timer_flags_next.irq = 1'b0;
                        end
                    end
                    REG_WRITE_DATA: begin
                        if (io_enable_reg) begin
                            data_byte_next         = item.write_value;
                            drive_status_next.xfer = 1'b0;
                        end
                        drive_status_next.irq = 1'b0;
                    end
                    REG_DRIVE_CTRL: begin
                        if (io_enable_reg) begin
                            drive_ctrl_next.power = item.write_value[0];
                            drive_ctrl_next.halt  = item.write_value[1];
                            drive_ctrl_next.rd    = item.write_value[2];
                            drive_ctrl_next.crc   = item.write_value[4];
                            drive_ctrl_next.ready = item.write_value[6];
                            drive_ctrl_next.irqen = item.write_value[7];
                            mirror_next           = item.write_value[3];
                        end
                        drive_status_next.irq = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            KIND_INSERT: begin
                drive_status_next.empty    = 1'b1;
                drive_status_next.gap      = 1'b1;
                drive_status_next.scanning = 1'b0;
                offset_next                = '0;
                wait_next                  = WAIT_INSERT;
            end
            default: begin
            end
        endcase

        result.timer_irq            = timer_flags_next.irq;
        result.drive_irq            = drive_status_next.irq;
        result.nametable_horizontal = mirror_next;
    end

    assign disk_length_next = cfg_wr_en ? cfg_wr_data : disk_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_length_reg  <= LENGTH_RESET;
            data_byte_reg    <= '0;
            io_enable_reg    <= 1'b0;
            mirror_reg       <= 1'b0;
            timer_reload_reg <= '0;
            timer_count_reg  <= '0;
            timer_flags_reg  <= '0;
            drive_ctrl_reg   <= '0;
            drive_status_reg <= '0;
            offset_reg       <= '0;
            wait_reg         <= '0;
        end else begin
            disk_length_reg <= disk_length_next;
            if (step) begin
                data_byte_reg    <= data_byte_next;
                io_enable_reg    <= io_enable_next;
                mirror_reg       <= mirror_next;
                timer_reload_reg <= timer_reload_next;
                timer_count_reg  <= timer_count_next;
                timer_flags_reg  <= timer_flags_next;
                drive_ctrl_reg   <= drive_ctrl_next;
                drive_status_reg <= drive_status_next;
                offset_reg       <= offset_next;
                wait_reg         <= wait_next;
            end
        end
    end

endmodule

>>> sv/disk_drive_timer_controller.sv
// ----------------------------------------------------------------------------
// disk_drive_timer_controller
// Disk drive controller with interval timer: input register, single-pass
// update logic and result register.
// A request passes through the input register, then the result register,
// before its result is valid at the output.
// Throughput: one request per cycle; the input register and result register
// both advance whenever the result register is empty or being drained.
// Reset (aresetn low, synchronous): pipeline emptied, all controller state
// cleared, disk length set to 65536.
// ----------------------------------------------------------------------------
module disk_drive_timer_controller import dtc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // reg_index[4:0], write_value[12:5], disk_byte[20:13]
    input  logic [1:0]          s_tuser,   // kind[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // read_value[7:0], timer_irq[8], drive_irq[9],
                                           // disk_address[26:10], disk_write[27],
                                           // disk_write_data[35:28], nametable_horizontal[36]
    input  logic                cfg_wr_en,
    input  logic [LENGTH_W-1:0] cfg_wr_data
);

    logic    in_valid_reg,  in_valid_next;
    item_t   in_item_reg,   in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;
    result_t core_result;
    logic    advance;
    logic    step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_tvalid && s_tready) begin
            in_item_next.kind        = kind_t'(s_tuser);
            in_item_next.reg_index   = s_tdata[4:0];
            in_item_next.write_value = s_tdata[12:5];
            in_item_next.disk_byte   = s_tdata[20:13];
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
        out_data_next  = step ? core_result : out_data_reg;
    end

    dtc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .item        (in_item_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_data_reg};

endmodule

>>> sv/dtc_checker.sv
// ----------------------------------------------------------------------------
// dtc_checker
// Port-level checks on the disk drive and timer controller.
// ----------------------------------------------------------------------------
module dtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_write_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[27] |-> m_tdata[35:28] == 8'd0)
        else $error("write data without disk write");

    a_read_no_disk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] != 8'd0 |-> !m_tdata[27] && m_tdata[26:10] == 17'd0)
        else $error("register read result with disk access");

    a_accept_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result side empty");

endmodule

bind disk_drive_timer_controller dtc_checker u_dtc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
